>>> rtl/tsw_pkg.sv
// Package for the timeout slot watchdog: operation codes, result kinds,
// register indexes, reset values and the controller/datapath interface structs.
`default_nettype none
package tsw_pkg;

    localparam int SLOTS_DEFAULT = 16;
    localparam int SLOT_W = 4;
    localparam int TO_W = 16;
    localparam int TIME_W = 32;
    localparam int KIND_W = 3;
    localparam int OP_W = 2;

    localparam logic [OP_W-1:0] OP_REGISTER   = 2'd0;
    localparam logic [OP_W-1:0] OP_DEREGISTER = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK       = 2'd2;
    localparam logic [OP_W-1:0] OP_QUERY      = 2'd3;

    localparam logic [KIND_W-1:0] KIND_REGISTERED   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DEREGISTERED = 3'd1;
    localparam logic [KIND_W-1:0] KIND_STATUS       = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ALERT        = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TICK_DONE    = 3'd4;

    localparam logic [1:0] REG_MIN_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_MAX_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_DEFAULT_TO  = 2'd2;
    localparam logic [1:0] REG_HEARTBEAT   = 2'd3;

    localparam logic [TO_W-1:0] RST_MIN_TIMEOUT = 16'd1;
    localparam logic [TO_W-1:0] RST_MAX_TIMEOUT = 16'd300;
    localparam logic [TO_W-1:0] RST_DEFAULT_TO  = 16'd30;
    localparam logic [TO_W-1:0] RST_HEARTBEAT   = 16'd10;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the accepted transaction
        logic exec;      // run the single-slot operation
        logic tick_init; // advance the clock and start the scan at slot 0
        logic scan_step; // evaluate the current scan slot and advance
        logic emit_done; // present the tick-done result
    } tsw_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_tick;
        logic scan_last;  // current scan slot is the final slot
    } tsw_status_t;

endpackage
`default_nettype wire

>>> rtl/tsw_ctrl.sv
// Controller state machine of the timeout slot watchdog.
// Depends on tsw_pkg for the command and status structs.
`default_nettype none
module tsw_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_fire,
    input  wire logic                 out_busy,
    input  wire tsw_pkg::tsw_status_t status,
    output logic                      in_ready,
    output tsw_pkg::tsw_cmd_t         cmd
);
    import tsw_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_DONE,
        ST_DRAIN
    } state_t;

    state_t state_reg, state_next;

    // Next state and commands; an output slot must be free to emit.
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_fire)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (status.is_tick)
                begin
                    cmd.tick_init = 1'b1;
                    state_next = ST_SCAN;
                end
                else if (!out_busy)
                begin
                    cmd.exec = 1'b1;
                    state_next = ST_DRAIN;
                end
            end
            ST_SCAN:
            begin
                if (!out_busy)
                begin
                    cmd.scan_step = 1'b1;
                    if (status.scan_last)
                        state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_busy)
                begin
                    cmd.emit_done = 1'b1;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                in_ready = 1'b1;
                if (in_fire)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_DECODE;
                end
                else
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Only one command may be active in any cycle.
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.exec, cmd.tick_init, cmd.scan_step, cmd.emit_done}))
        else $error("controller issued overlapping commands");
    a_no_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec || cmd.scan_step || cmd.emit_done) |-> !out_busy)
        else $error("result produced while output register full");
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (state_reg == ST_IDLE || state_reg == ST_DRAIN))
        else $error("transaction loaded mid-operation");

endmodule
`default_nettype wire

>>> rtl/tsw_datapath.sv
// Datapath of the timeout slot watchdog: slot table, clock, scan and result register.
// Depends on tsw_pkg for codes and the command and status structs.
`default_nettype none
module tsw_datapath #(
    parameter int SLOTS = tsw_pkg::SLOTS_DEFAULT
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire tsw_pkg::tsw_cmd_t           cmd,
    output tsw_pkg::tsw_status_t             status,
    input  wire logic [tsw_pkg::OP_W-1:0]    opcode,
    input  wire logic [tsw_pkg::SLOT_W-1:0]  slot,
    input  wire logic [tsw_pkg::TO_W-1:0]    requested_timeout,
    input  wire logic                        has_connection,
    input  wire logic [tsw_pkg::TO_W-1:0]    min_timeout,
    input  wire logic [tsw_pkg::TO_W-1:0]    max_timeout,
    input  wire logic [tsw_pkg::TO_W-1:0]    default_timeout,
    input  wire logic [tsw_pkg::TO_W-1:0]    heartbeat_period,
    input  wire logic                        out_ready,
    output logic                             out_valid,
    output logic [tsw_pkg::KIND_W-1:0]       kind,
    output logic                             ok,
    output logic [tsw_pkg::SLOT_W-1:0]       slot_out,
    output logic [tsw_pkg::TO_W-1:0]         timeout_out,
    output logic [tsw_pkg::TIME_W-1:0]       elapsed,
    output logic                             cancel_request,
    output logic [$clog2(SLOTS+1)-1:0]       active_count,
    output logic                             last
);
    import tsw_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    // Captured transaction.
    logic [OP_W-1:0]   op_reg;
    logic [SLOT_W-1:0] sl_reg;
    logic [TO_W-1:0]   req_reg;
    logic              conn_reg;

    // Slot table: flags in flip-flops, payload fields written before read.
    logic [SLOTS-1:0]  valid_reg, expired_reg, alerted_reg, cancelled_reg, conn_tab_reg;
    logic [TIME_W-1:0] start_reg [SLOTS];
    logic [TIME_W-1:0] alert_t_reg [SLOTS];
    logic [TO_W-1:0]   to_reg [SLOTS];
    logic [TIME_W-1:0] now_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [IDX_W-1:0]  scan_reg;

    // Output register.
    logic              ov_reg;
    logic [KIND_W-1:0] kind_reg;
    logic              ok_reg, cancel_reg, last_reg;
    logic [SLOT_W-1:0] so_reg;
    logic [TO_W-1:0]   to_out_reg;
    logic [TIME_W-1:0] el_reg;
    logic [CNT_W-1:0]  ac_reg;

    // Lowest free slot.
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    always_comb
    begin
        free_found = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    // Effective timeout of the request.
    logic [TO_W-1:0] lo_bound, eff_to;
    always_comb
    begin
        lo_bound = (min_timeout > max_timeout) ? max_timeout : min_timeout;
        if (req_reg == '0)
            eff_to = default_timeout;
        else if (req_reg < lo_bound)
            eff_to = lo_bound;
        else if (req_reg > max_timeout)
            eff_to = max_timeout;
        else
            eff_to = req_reg;
    end

    // Addressed slot for deregister and query.
    logic             sel_in_range;
    logic [IDX_W-1:0] sel_idx;
    logic             sel_hit;
    assign sel_in_range = ({28'd0, sl_reg} < 32'(SLOTS));
    assign sel_idx = IDX_W'(sl_reg);
    assign sel_hit = sel_in_range && valid_reg[sel_idx];

    // Scan evaluation of the current slot.
    logic [TIME_W-1:0] scan_el;
    logic              scan_exp, scan_alert, scan_cancel;
    always_comb
    begin
        scan_el = now_reg - start_reg[scan_reg];
        scan_exp = expired_reg[scan_reg] || (scan_el >= {16'd0, to_reg[scan_reg]});
        scan_alert = valid_reg[scan_reg] && scan_exp &&
            !(alerted_reg[scan_reg] &&
              ((now_reg - alert_t_reg[scan_reg]) < {16'd0, heartbeat_period}));
        scan_cancel = !cancelled_reg[scan_reg] && conn_tab_reg[scan_reg];
    end

    assign status.is_tick = (op_reg == OP_TICK);
    assign status.scan_last = (scan_reg == IDX_W'(SLOTS - 1));

    // Captured transaction fields.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= opcode;
            sl_reg <= slot;
            req_reg <= requested_timeout;
            conn_reg <= has_connection;
        end
    end

    // Slot payload stores.
    always_ff @(posedge clk)
    begin
        if (cmd.exec && op_reg == OP_REGISTER && free_found)
        begin
            start_reg[free_idx] <= now_reg;
            to_reg[free_idx] <= eff_to;
            conn_tab_reg[free_idx] <= conn_reg;
        end
        if (cmd.scan_step && scan_alert)
            alert_t_reg[scan_reg] <= now_reg;
    end

    // Control state of the table, clock, scan pointer and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            expired_reg <= '0;
            alerted_reg <= '0;
            cancelled_reg <= '0;
            now_reg <= '0;
            count_reg <= '0;
            scan_reg <= '0;
            ov_reg <= 1'b0;
            kind_reg <= '0;
            ok_reg <= 1'b0;
            so_reg <= '0;
            to_out_reg <= '0;
            el_reg <= '0;
            cancel_reg <= 1'b0;
            ac_reg <= '0;
            last_reg <= 1'b0;
        end
        else
        begin
            if (ov_reg && out_ready)
                ov_reg <= 1'b0;
            if (cmd.exec)
            begin
                ov_reg <= 1'b1;
                el_reg <= '0;
                cancel_reg <= 1'b0;
                last_reg <= 1'b1;
                unique case (op_reg)
                    OP_REGISTER:
                    begin
                        kind_reg <= KIND_REGISTERED;
                        ok_reg <= free_found;
                        if (free_found)
                        begin
                            valid_reg[free_idx] <= 1'b1;
                            expired_reg[free_idx] <= 1'b0;
                            alerted_reg[free_idx] <= 1'b0;
                            cancelled_reg[free_idx] <= 1'b0;
                            count_reg <= count_reg + 1'b1;
                            ac_reg <= count_reg + 1'b1;
                            so_reg <= SLOT_W'(free_idx);
                            to_out_reg <= eff_to;
                        end
                        else
                        begin
                            ac_reg <= count_reg;
                            so_reg <= '0;
                            to_out_reg <= '0;
                        end
                    end
                    OP_DEREGISTER:
                    begin
                        kind_reg <= KIND_DEREGISTERED;
                        ok_reg <= sel_hit;
                        so_reg <= sl_reg;
                        if (sel_hit)
                        begin
                            valid_reg[sel_idx] <= 1'b0;
                            count_reg <= count_reg - 1'b1;
                            ac_reg <= count_reg - 1'b1;
                            to_out_reg <= to_reg[sel_idx];
                        end
                        else
                        begin
                            ac_reg <= count_reg;
                            to_out_reg <= '0;
                        end
                    end
                    default:
                    begin
                        kind_reg <= KIND_STATUS;
                        ok_reg <= sel_hit && expired_reg[sel_idx];
                        so_reg <= sl_reg;
                        to_out_reg <= sel_hit ? to_reg[sel_idx] : '0;
                        ac_reg <= count_reg;
                    end
                endcase
            end
            if (cmd.tick_init)
            begin
                now_reg <= now_reg + 1'b1;
                scan_reg <= '0;
            end
            if (cmd.scan_step)
            begin
                if (!status.scan_last)
                    scan_reg <= scan_reg + 1'b1;
                if (valid_reg[scan_reg] && scan_exp)
                    expired_reg[scan_reg] <= 1'b1;
                if (scan_alert)
                begin
                    alerted_reg[scan_reg] <= 1'b1;
                    if (scan_cancel)
                        cancelled_reg[scan_reg] <= 1'b1;
                    ov_reg <= 1'b1;
                    kind_reg <= KIND_ALERT;
                    ok_reg <= 1'b1;
                    so_reg <= SLOT_W'(scan_reg);
                    to_out_reg <= to_reg[scan_reg];
                    el_reg <= scan_el;
                    cancel_reg <= scan_cancel;
                    ac_reg <= count_reg;
                    last_reg <= 1'b0;
                end
            end
            if (cmd.emit_done)
            begin
                ov_reg <= 1'b1;
                kind_reg <= KIND_TICK_DONE;
                ok_reg <= 1'b1;
                so_reg <= '0;
                to_out_reg <= '0;
                el_reg <= '0;
                cancel_reg <= 1'b0;
                ac_reg <= count_reg;
                last_reg <= 1'b1;
            end
        end
    end

    assign out_valid = ov_reg;
    assign kind = kind_reg;
    assign ok = ok_reg;
    assign slot_out = so_reg;
    assign timeout_out = to_out_reg;
    assign elapsed = el_reg;
    assign cancel_request = cancel_reg;
    assign active_count = ac_reg;
    assign last = last_reg;

    // The occupancy count always matches the valid bits.
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) == $countones(valid_reg))
        else $error("occupancy count disagrees with valid bits");
    a_cancel_alert: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && cancel_reg) |-> (kind_reg == KIND_ALERT))
        else $error("cancel request outside an alert");
    a_expired_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.scan_step && scan_alert) |=> expired_reg[$past(scan_reg)])
        else $error("alert on a slot not marked expired");

endmodule
`default_nettype wire

>>> rtl/tsw_regs.sv
// Configuration register file of the timeout slot watchdog on an APB-style port.
// Depends on tsw_pkg for register indexes and reset values.
`default_nettype none
module tsw_regs (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [3:0]                paddr,
    input  wire logic [31:0]               pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output logic [tsw_pkg::TO_W-1:0]       min_timeout,
    output logic [tsw_pkg::TO_W-1:0]       max_timeout,
    output logic [tsw_pkg::TO_W-1:0]       default_timeout,
    output logic [tsw_pkg::TO_W-1:0]       heartbeat_period
);
    import tsw_pkg::*;

    logic [TO_W-1:0] min_reg, max_reg, def_reg, hb_reg;
    logic            wr;
    logic [1:0]      idx;

    assign pready = 1'b1;
    assign idx = paddr[3:2];
    assign wr = psel && penable && pwrite && (pwdata[15:0] != '0);

    // Writes of zero are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= RST_MIN_TIMEOUT;
            max_reg <= RST_MAX_TIMEOUT;
            def_reg <= RST_DEFAULT_TO;
            hb_reg <= RST_HEARTBEAT;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_MIN_TIMEOUT: min_reg <= pwdata[15:0];
                REG_MAX_TIMEOUT: max_reg <= pwdata[15:0];
                REG_DEFAULT_TO:  def_reg <= pwdata[15:0];
                default:         hb_reg <= pwdata[15:0];
            endcase
        end
    end

    // Read data.
    always_comb
    begin
        unique case (idx)
            REG_MIN_TIMEOUT: prdata = {16'd0, min_reg};
            REG_MAX_TIMEOUT: prdata = {16'd0, max_reg};
            REG_DEFAULT_TO:  prdata = {16'd0, def_reg};
            default:         prdata = {16'd0, hb_reg};
        endcase
    end

    assign min_timeout = min_reg;
    assign max_timeout = max_reg;
    assign default_timeout = def_reg;
    assign heartbeat_period = hb_reg;

endmodule
`default_nettype wire

>>> rtl/timeout_slot_watchdog.sv
// Top level of the timeout slot watchdog: registers, controller and datapath.
// Register, deregister and query are captured, then executed in the decode state once the output
// register is free, which registers their result; one transaction is handled at a time.
// A tick advances the clock, then scans the slots in order in the shared evaluation unit,
// holding while the output register is busy, and then presents its tick-done result.
// Output stalls hold the controller; the next item is taken as the last result is presented.
// rst_n (asynchronous, active low) frees every slot, zeroes the clock and restores registers.
// Depends on tsw_pkg, tsw_regs, tsw_ctrl and tsw_datapath.
`default_nettype none
module timeout_slot_watchdog #(
    parameter int SLOTS = tsw_pkg::SLOTS_DEFAULT
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [3:0]                  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [tsw_pkg::OP_W-1:0]    opcode,
    input  wire logic [tsw_pkg::SLOT_W-1:0]  slot,
    input  wire logic [tsw_pkg::TO_W-1:0]    requested_timeout,
    input  wire logic                        has_connection,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [tsw_pkg::KIND_W-1:0]       kind,
    output logic                             ok,
    output logic [tsw_pkg::SLOT_W-1:0]       slot_out,
    output logic [tsw_pkg::TO_W-1:0]         timeout_out,
    output logic [tsw_pkg::TIME_W-1:0]       elapsed,
    output logic                             cancel_request,
    output logic [$clog2(SLOTS+1)-1:0]       active_count,
    output logic                             last
);
    import tsw_pkg::*;

    logic [TO_W-1:0] min_to, max_to, def_to, hb;
    tsw_cmd_t        cmd;
    tsw_status_t     status;
    logic            out_busy;

    // The output register is busy while it holds a result not taken this cycle.
    assign out_busy = out_valid && !out_ready;

    tsw_regs u_regs (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .min_timeout(min_to), .max_timeout(max_to), .default_timeout(def_to),
        .heartbeat_period(hb)
    );

    tsw_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_valid && in_ready),
        .out_busy(out_busy), .status(status), .in_ready(in_ready), .cmd(cmd)
    );

    tsw_datapath #(.SLOTS(SLOTS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
        .opcode(opcode), .slot(slot), .requested_timeout(requested_timeout),
        .has_connection(has_connection),
        .min_timeout(min_to), .max_timeout(max_to), .default_timeout(def_to),
        .heartbeat_period(hb), .out_ready(out_ready), .out_valid(out_valid),
        .kind(kind), .ok(ok), .slot_out(slot_out), .timeout_out(timeout_out),
        .elapsed(elapsed), .cancel_request(cancel_request),
        .active_count(active_count), .last(last)
    );

endmodule
`default_nettype wire
